FILE: sv/pid_controller_with_twiddle_tuning_defines.svh
`ifndef PID_CONTROLLER_WITH_TWIDDLE_TUNING_DEFINES_SVH
`define PID_CONTROLLER_WITH_TWIDDLE_TUNING_DEFINES_SVH

// check on every clock edge, masked while in reset
`define PIDTW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check on the edge after the trigger
`define PIDTW_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

FILE: sv/pidtw_pkg.sv
package pidtw_pkg;

	localparam int unsigned ERR_W      = 32;
	localparam int unsigned INTEG_W    = 48;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned SCORE_W    = 64;
	localparam int unsigned STEPS_W    = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned USER_W     = 3;
	localparam int unsigned NUM_GAINS  = 3;
	localparam int unsigned QUOT_W     = 29;
	localparam int unsigned SUM_W      = 66;

	typedef logic signed [ERR_W-1:0] q16_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TUNING_ENABLE = 3'd0,
		REG_KP_INITIAL    = 3'd1,
		REG_KI_INITIAL    = 3'd2,
		REG_KD_INITIAL    = 3'd3,
		REG_SETTLE_STEPS  = 3'd4,
		REG_LOOP_STEPS    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		GAIN_P = 2'd0,
		GAIN_I = 2'd1,
		GAIN_D = 2'd2
	} gain_sel_t;

	localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
	localparam q16_t Q16_MIN = 32'sh8000_0000;

	localparam q16_t KP_RESET = 32'sd21597;
	localparam q16_t KI_RESET = 32'sd655;
	localparam q16_t KD_RESET = 32'sd508363;
	localparam q16_t DP_P_RESET = 32'sd2159;
	localparam q16_t DP_I_RESET = 32'sd65;
	localparam q16_t DP_D_RESET = 32'sd50836;

	localparam logic [STEPS_W-1:0] SETTLE_RESET = 16'd100;
	localparam logic [STEPS_W-1:0] LOOP_RESET   = 16'd1150;

	// floor(m / 10) == (m * RECIP10) >> 35 for any 32-bit m
	localparam logic [ERR_W-1:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int unsigned RECIP10_SHIFT = 35;

	function automatic logic [QUOT_W-1:0] div10(input logic [ERR_W-1:0] m);
		logic [2*ERR_W-1:0] p;
		p = (2*ERR_W)'(m) * (2*ERR_W)'(RECIP10);
		return p[RECIP10_SHIFT +: QUOT_W];
	endfunction

	function automatic q16_t sat_q16(input logic signed [35:0] v);
		q16_t r;
		if (v > 36'sd2147483647) begin
			r = Q16_MAX;
		end else if (v < -36'sd2147483648) begin
			r = Q16_MIN;
		end else begin
			r = v[ERR_W-1:0];
		end
		return r;
	endfunction

	function automatic gain_sel_t next_gain(input gain_sel_t g);
		gain_sel_t r;
		unique case (g)
			GAIN_P:  r = GAIN_I;
			GAIN_I:  r = GAIN_D;
			GAIN_D:  r = GAIN_P;
			default: r = GAIN_P;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/pid_controller_with_twiddle_tuning.sv
// PID controller with twiddle gain tuning. One Q16.16 error sample per transfer on the slave
// stream, one result per sample on the master stream: drive = -(Kp*e + Ki*I + Kd*(e - e_prev))
// saturated to 32 bits, plus the run-finished flag and the index of the gain being tuned.
// A new sample is taken every clock cycle unless the master stream backs up; each result passes
// in order through the pipeline of input register, integrator/step counter, twiddle update,
// products, sum and output register. The step-size growth and shrink values are kept ready
// by a registered divide-by-ten unit per gain. Configuration writes are meant for idle times.
`include "pid_controller_with_twiddle_tuning_defines.svh"

module pid_controller_with_twiddle_tuning (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [pidtw_pkg::ERR_W-1:0]     s_axis_tdata,  // [31:0] cross_track_error
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [pidtw_pkg::ERR_W-1:0]     m_axis_tdata,  // [31:0] drive
	output logic [pidtw_pkg::USER_W-1:0]    m_axis_tuser,  // [0] run_finished, [2:1] tuned_gain_index
	input  logic                            cfg_we,
	input  logic [pidtw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pidtw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pidtw_pkg::*;

	// configuration
	logic                 tune_en_q;
	logic [STEPS_W-1:0]   settle_q;
	logic [STEPS_W-1:0]   loop_q;
	logic                 cfg_gain_c;
	gain_sel_t            cfg_sel_c;
	logic [ERR_W-1:0]     cfg_mag_c;
	logic [QUOT_W-1:0]    cfg_div_c;
	q16_t                 cfg_dp_c;

	// pipeline control
	logic en1, en2, en3, en4, en5, en_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic mv1, mv2;

	// stage 1
	q16_t                 e_s1;
	q16_t                 last_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic [CNT_W-1:0]     step_cnt_q;
	logic signed [ERR_W:0] d_c;
	logic [INTEG_W:0]     integ_sum_c;
	logic signed [INTEG_W-1:0] integ_c;
	logic [ERR_W-1:0]     mag_e_c;
	logic [CNT_W-1:0]     cnt_inc_c;
	logic [CNT_W-1:0]     run_len_c;
	logic                 end_c;

	// stage 2
	q16_t                 e_s2;
	logic signed [ERR_W:0] d_s2;
	logic signed [INTEG_W-1:0] integ_s2;
	logic [SCORE_W-1:0]   sq_s2;
	logic                 score_s2, end_s2, clr_s2;

	// twiddle state
	q16_t                 gains_q [NUM_GAINS];
	q16_t                 best_gains_q [NUM_GAINS];
	q16_t                 dp_q [NUM_GAINS];
	q16_t                 grow_q [NUM_GAINS];
	q16_t                 shrink_q [NUM_GAINS];
	gain_sel_t            idx_q;
	logic                 raised_q, lowered_q, first_q, fin_q;
	logic [SCORE_W-1:0]   score_q, best_score_q;

	q16_t                 gains_n [NUM_GAINS];
	q16_t                 best_gains_n [NUM_GAINS];
	q16_t                 dp_n [NUM_GAINS];
	gain_sel_t            idx_n;
	logic                 raised_n, lowered_n, first_n, fin_n;
	logic [SCORE_W-1:0]   score_n, best_score_n;
	logic [SCORE_W:0]     score_add_c;
	q16_t                 gk_c, dpk_c, up_c, down_c;

	// stage 3..5
	q16_t                 e_s3;
	logic signed [ERR_W:0] d_s3;
	logic signed [INTEG_W-1:0] integ_s3;
	q16_t                 g_s3 [NUM_GAINS];
	logic                 fin_s3, fin_s4, fin_s5;
	gain_sel_t            idx_s3, idx_s4, idx_s5;
	logic signed [2*ERR_W-1:0]  p0_c, p1h_c, p0_s4, p1h_s4;
	logic signed [2*ERR_W:0]    p2_c, p2_s4;
	logic signed [ERR_W+16:0]   p1l_c, p1l_s4;
	logic signed [SUM_W-1:0]    sum_c, sum_s5, neg_c;
	logic                       fits_c;

	// output register
	logic                 out_valid_q;
	q16_t                 out_drive_q;
	logic                 out_fin_q;
	gain_sel_t            out_idx_q;

	assign en_out = !out_valid_q || m_axis_tready;
	assign en5 = !v_s5 || en_out;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign mv1 = v_s1 && en2;
	assign mv2 = v_s2 && en3;

	assign s_axis_tready = en1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_drive_q;
	assign m_axis_tuser  = {out_idx_q, out_fin_q};

	// ---------------------------------------------------------------- configuration
	always_comb begin
		cfg_gain_c = 1'b0;
		cfg_sel_c  = GAIN_P;
		unique case (cfg_reg_t'(cfg_index))
			REG_KP_INITIAL: begin
				cfg_gain_c = 1'b1;
				cfg_sel_c  = GAIN_P;
			end
			REG_KI_INITIAL: begin
				cfg_gain_c = 1'b1;
				cfg_sel_c  = GAIN_I;
			end
			REG_KD_INITIAL: begin
				cfg_gain_c = 1'b1;
				cfg_sel_c  = GAIN_D;
			end
			default: cfg_gain_c = 1'b0;
		endcase
	end

	// initial step is the gain / 10, truncated toward zero
	assign cfg_mag_c = cfg_data[ERR_W-1] ? (~cfg_data + 32'd1) : cfg_data;
	assign cfg_div_c = div10(cfg_mag_c);
	assign cfg_dp_c  = cfg_data[ERR_W-1] ? (~{3'b0, cfg_div_c} + 32'd1) : {3'b0, cfg_div_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_en_q <= 1'b0;
			settle_q  <= SETTLE_RESET;
			loop_q    <= LOOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TUNING_ENABLE: tune_en_q <= cfg_data[0];
				REG_SETTLE_STEPS:  settle_q  <= cfg_data[STEPS_W-1:0];
				REG_LOOP_STEPS:    loop_q    <= cfg_data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && en1) begin
			e_s1 <= s_axis_tdata;
		end
	end

	// ---------------------------------------------------------------- stage 1: integrator, step count
	assign d_c         = {e_s1[ERR_W-1], e_s1} - {last_q[ERR_W-1], last_q};
	assign integ_sum_c = {integ_q[INTEG_W-1], integ_q} + {{(INTEG_W-ERR_W+1){e_s1[ERR_W-1]}}, e_s1};
	assign integ_c     = (integ_sum_c[INTEG_W] != integ_sum_c[INTEG_W-1])
		? (integ_sum_c[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}})
		: integ_sum_c[INTEG_W-1:0];
	assign mag_e_c     = e_s1[ERR_W-1] ? (~e_s1 + 32'd1) : e_s1;
	assign cnt_inc_c   = step_cnt_q + 17'd1;
	assign run_len_c   = {1'b0, settle_q} + {1'b0, loop_q};
	assign end_c       = cnt_inc_c >= run_len_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			integ_q    <= '0;
			step_cnt_q <= '0;
		end else if (mv1) begin
			last_q     <= e_s1;
			integ_q    <= integ_c;
			step_cnt_q <= end_c ? '0 : cnt_inc_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			e_s2     <= e_s1;
			d_s2     <= d_c;
			integ_s2 <= integ_c;
			sq_s2    <= SCORE_W'(mag_e_c) * SCORE_W'(mag_e_c);
			score_s2 <= tune_en_q && (cnt_inc_c > {1'b0, settle_q}) && (cnt_inc_c < run_len_c);
			end_s2   <= tune_en_q && end_c;
			clr_s2   <= tune_en_q && (step_cnt_q == '0);
		end
	end

	// ---------------------------------------------------------------- step size growth / shrink
	// grow = dp*11/10 = dp + dp/10 and shrink = dp*9/10 = dp - ceil(dp/10), on magnitudes
	for (genvar k = 0; k < NUM_GAINS; k++) begin : g_lane
		logic [ERR_W-1:0]  mag_c;
		logic [ERR_W-1:0]  mag_q;
		logic              neg_q;
		logic [QUOT_W-1:0] div_q;
		logic [ERR_W-1:0]  rem_c;
		logic [QUOT_W-1:0] ceil_c;
		logic [ERR_W:0]    grow_mag_c;
		logic [ERR_W-1:0]  shrink_mag_c;

		assign mag_c = dp_q[k][ERR_W-1] ? (~dp_q[k] + 32'd1) : dp_q[k];

		always_ff @(posedge clk) begin
			mag_q <= mag_c;
			neg_q <= dp_q[k][ERR_W-1];
			div_q <= div10(mag_c);
		end

		assign rem_c        = mag_q - ({div_q, 3'b0} + {2'b0, div_q, 1'b0});
		assign ceil_c       = div_q + QUOT_W'(rem_c != '0);
		assign grow_mag_c   = {1'b0, mag_q} + {4'b0, div_q};
		assign shrink_mag_c = mag_q - {3'b0, ceil_c};

		always_ff @(posedge clk) begin
			grow_q[k]   <= neg_q ? sat_q16(-$signed({3'b0, grow_mag_c}))
				: sat_q16($signed({3'b0, grow_mag_c}));
			shrink_q[k] <= neg_q ? (~shrink_mag_c + 32'd1) : shrink_mag_c;
		end
	end

	// ---------------------------------------------------------------- stage 2: score and twiddle
	assign gk_c        = gains_q[idx_q];
	assign dpk_c       = dp_q[idx_q];
	assign up_c        = sat_q16(36'(gk_c) + 36'(dpk_c));
	assign down_c      = sat_q16(36'(gk_c) - 36'(dpk_c) - 36'(dpk_c));
	assign score_add_c = {1'b0, score_q} + {1'b0, sq_s2};

	always_comb begin
		gains_n      = gains_q;
		best_gains_n = best_gains_q;
		dp_n         = dp_q;
		idx_n        = idx_q;
		raised_n     = raised_q;
		lowered_n    = lowered_q;
		first_n      = first_q;
		best_score_n = best_score_q;
		fin_n        = fin_q && !clr_s2;
		score_n      = score_q;
		if (score_s2) begin
			score_n = score_add_c[SCORE_W] ? '1 : score_add_c[SCORE_W-1:0];
		end
		if (end_s2) begin
			priority if (score_q < best_score_q) begin
				best_score_n = score_q;
				if (first_q) begin
					dp_n[idx_q] = grow_q[idx_q];
				end
				best_gains_n = gains_q;
				idx_n        = next_gain(idx_q);
				raised_n     = 1'b0;
				lowered_n    = 1'b0;
			end else if (!raised_q) begin
				gains_n[idx_q] = up_c;
				raised_n       = 1'b1;
			end else if (!lowered_q) begin
				gains_n[idx_q] = down_c;
				lowered_n      = 1'b1;
			end else begin
				gains_n[idx_q] = up_c;
				dp_n[idx_q]    = shrink_q[idx_q];
				idx_n          = next_gain(idx_q);
				raised_n       = 1'b0;
				lowered_n      = 1'b0;
			end
			score_n = '0;
			fin_n   = 1'b1;
			first_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q[GAIN_P]      <= KP_RESET;
			gains_q[GAIN_I]      <= KI_RESET;
			gains_q[GAIN_D]      <= KD_RESET;
			best_gains_q[GAIN_P] <= KP_RESET;
			best_gains_q[GAIN_I] <= KI_RESET;
			best_gains_q[GAIN_D] <= KD_RESET;
			dp_q[GAIN_P]         <= DP_P_RESET;
			dp_q[GAIN_I]         <= DP_I_RESET;
			dp_q[GAIN_D]         <= DP_D_RESET;
		end else if (cfg_we && cfg_gain_c) begin
			gains_q[cfg_sel_c]      <= cfg_data;
			best_gains_q[cfg_sel_c] <= cfg_data;
			dp_q[cfg_sel_c]         <= cfg_dp_c;
		end else if (mv2) begin
			gains_q      <= gains_n;
			best_gains_q <= best_gains_n;
			dp_q         <= dp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= GAIN_P;
			raised_q     <= 1'b0;
			lowered_q    <= 1'b0;
			first_q      <= 1'b0;
			fin_q        <= 1'b0;
			score_q      <= '0;
			best_score_q <= '1;
		end else if (mv2) begin
			idx_q        <= idx_n;
			raised_q     <= raised_n;
			lowered_q    <= lowered_n;
			first_q      <= first_n;
			fin_q        <= fin_n;
			score_q      <= score_n;
			best_score_q <= best_score_n;
		end
	end

	// ---------------------------------------------------------------- stages 3..5: products, sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			e_s3     <= e_s2;
			d_s3     <= d_s2;
			integ_s3 <= integ_s2;
			g_s3     <= gains_n;
			fin_s3   <= fin_n;
			idx_s3   <= idx_n;
		end
	end

	// integral product split into high word and low 16 bits: floor(g*I/2^16) = g*I_hi + floor(g*I_lo/2^16)
	assign p0_c  = g_s3[GAIN_P] * e_s3;
	assign p1h_c = g_s3[GAIN_I] * $signed(integ_s3[INTEG_W-1:16]);
	assign p1l_c = g_s3[GAIN_I] * $signed({1'b0, integ_s3[15:0]});
	assign p2_c  = g_s3[GAIN_D] * d_s3;

	always_ff @(posedge clk) begin
		if (v_s3 && en4) begin
			p0_s4  <= p0_c;
			p1h_s4 <= p1h_c;
			p1l_s4 <= p1l_c;
			p2_s4  <= p2_c;
			fin_s4 <= fin_s3;
			idx_s4 <= idx_s3;
		end
	end

	assign sum_c = SUM_W'(p0_s4 >>> 16) + SUM_W'(p1h_s4) + SUM_W'(p1l_s4 >>> 16)
		+ SUM_W'(p2_s4 >>> 16);

	always_ff @(posedge clk) begin
		if (v_s4 && en5) begin
			sum_s5 <= sum_c;
			fin_s5 <= fin_s4;
			idx_s5 <= idx_s4;
		end
	end

	assign neg_c  = -sum_s5;
	assign fits_c = (neg_c[SUM_W-1:ERR_W-1] == '0) || (neg_c[SUM_W-1:ERR_W-1] == '1);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s5 && en_out) begin
			out_drive_q <= fits_c ? neg_c[ERR_W-1:0] : (neg_c[SUM_W-1] ? Q16_MIN : Q16_MAX);
			out_fin_q   <= fin_s5;
			out_idx_q   <= idx_s5;
		end
	end

	// ---------------------------------------------------------------- checks
	`PIDTW_ASSERT(a_flag_order, !lowered_q || raised_q, "lowered without raised")
	`PIDTW_ASSERT(a_score_end_excl, !(v_s2 && score_s2 && end_s2), "scored step ends run")
	`PIDTW_ASSERT(a_stall_full, s_axis_tready || (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_valid_q && !m_axis_tready), "stall with room in pipeline")
	`PIDTW_ASSERT_NEXT(a_run_end, mv2 && end_s2, score_q == '0 && fin_q && first_q, "run end not applied")

endmodule

FILE: tb/sv/pid_controller_with_twiddle_tuning_tb.sv
`timescale 1ns / 1ps

module pid_controller_with_twiddle_tuning_tb;
	import pidtw_pkg::*;

	localparam int     STALL_LIMIT  = 2000;
	localparam int     DRAIN_CYCLES = 10;
	localparam int     MAX_PRINTS   = 40;
	localparam longint ERR_SUM_MAX  = 64'sh7FFF_FFFF_FFFF;
	localparam longint ERR_SUM_MIN  = -ERR_SUM_MAX - 1;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [31:0] drive;
		logic               run_done;
		gain_sel_t          tuned;
	} pid_output_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [ERR_W-1:0]       s_axis_tdata;   // [31:0] cross_track_error
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [ERR_W-1:0]       m_axis_tdata;   // [31:0] drive
	logic [USER_W-1:0]      m_axis_tuser;   // [0] run_finished, [2:1] tuned_gain_index
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	pid_controller_with_twiddle_tuning u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// controller settings and state as the block should hold them
	logic         tune_on;
	logic [15:0]  settle_len;
	logic [15:0]  loop_len;
	longint       prev_err;
	longint       err_sum;
	longint       gain_now[3];
	longint       gain_step[3];
	logic [16:0]  step_ctr;
	logic         tuned_once;
	gain_sel_t    tune_sel;
	logic         went_up;
	logic         went_down;
	logic [63:0]  best_cost;
	logic [63:0]  run_cost;
	logic         run_done;

	pid_output_t  queued_outputs[$];
	int           mismatches;
	int           samples_sent;
	int           results_checked;
	int           runs_closed;
	int           runs_improved;
	int           idle_cycles;
	int           ready_hold;
	bit           no_gaps;

	function automatic logic signed [31:0] clamp32(wide_t v);
		if (v > 128'sd2147483647)
			return Q16_MAX;
		if (v < -128'sd2147483648)
			return Q16_MIN;
		return v[31:0];
	endfunction

	// floor(g * x / 2^16)
	function automatic wide_t scaled_product(longint g, longint x);
		wide_t p;
		p = wide_t'(g) * wide_t'(x);
		return p >>> 16;
	endfunction

	function automatic void load_gain(int k, logic signed [31:0] v);
		gain_now[k]  = v;
		gain_step[k] = longint'(v) / 10;
	endfunction

	function automatic void reset_controller();
		tune_on    = 1'b0;
		settle_len = 16'd100;
		loop_len   = 16'd1150;
		prev_err   = 0;
		err_sum    = 0;
		load_gain(0, 32'sd21597);
		load_gain(1, 32'sd655);
		load_gain(2, 32'sd508363);
		step_ctr   = '0;
		tuned_once = 1'b0;
		tune_sel   = GAIN_P;
		went_up    = 1'b0;
		went_down  = 1'b0;
		best_cost  = '1;
		run_cost   = '0;
		run_done   = 1'b0;
	endfunction

	function automatic void apply_write(cfg_reg_t idx, logic [31:0] val);
		case (idx)
			REG_TUNING_ENABLE: tune_on = val[0];
			REG_KP_INITIAL:    load_gain(0, val);
			REG_KI_INITIAL:    load_gain(1, val);
			REG_KD_INITIAL:    load_gain(2, val);
			REG_SETTLE_STEPS:  settle_len = val[15:0];
			REG_LOOP_STEPS:    loop_len = val[15:0];
			default: ;
		endcase
	endfunction

	function automatic void advance_gain();
		tune_sel  = (tune_sel == GAIN_D) ? GAIN_P : gain_sel_t'(tune_sel + 2'd1);
		went_up   = 1'b0;
		went_down = 1'b0;
	endfunction

	// one twiddle step on the gain under tuning
	function automatic void close_run();
		int k;
		k = int'(tune_sel);
		runs_closed++;
		if (run_cost < best_cost) begin
			best_cost = run_cost;
			if (tuned_once)
				gain_step[k] = clamp32(wide_t'(gain_step[k] * 11 / 10));
			runs_improved++;
			advance_gain();
		end else if (!went_up) begin
			gain_now[k] = clamp32(wide_t'(gain_now[k] + gain_step[k]));
			went_up = 1'b1;
		end else if (!went_down) begin
			gain_now[k] = clamp32(wide_t'(gain_now[k] - 2 * gain_step[k]));
			went_down = 1'b1;
		end else begin
			gain_now[k] = clamp32(wide_t'(gain_now[k] + gain_step[k]));
			gain_step[k] = gain_step[k] * 9 / 10;
			advance_gain();
		end
		step_ctr   = '0;
		run_cost   = '0;
		run_done   = 1'b1;
		tuned_once = 1'b1;
	endfunction

	function automatic pid_output_t controller_step(logic signed [31:0] e_in);
		longint      e;
		longint      d;
		logic [17:0] run_len;
		logic [63:0] e_mag;
		logic [64:0] cost_acc;
		wide_t       total;
		pid_output_t r;
		e = e_in;
		d = e - prev_err;
		prev_err = e;
		err_sum = err_sum + e;
		if (err_sum > ERR_SUM_MAX)
			err_sum = ERR_SUM_MAX;
		else if (err_sum < ERR_SUM_MIN)
			err_sum = ERR_SUM_MIN;
		run_len = 18'(settle_len) + 18'(loop_len);
		if (tune_on && step_ctr == 0)
			run_done = 1'b0;
		step_ctr = step_ctr + 17'd1;
		if (tune_on) begin
			if (step_ctr > settle_len && step_ctr < run_len) begin
				e_mag = (e < 0) ? 64'(-e) : 64'(e);
				cost_acc = {1'b0, run_cost} + {1'b0, e_mag * e_mag};
				run_cost = cost_acc[64] ? '1 : cost_acc[63:0];
			end
			if (step_ctr >= run_len)
				close_run();
		end else if (step_ctr >= run_len) begin
			step_ctr = '0;
		end
		// drive sees the gains after this step's twiddle update
		total = scaled_product(gain_now[0], e) + scaled_product(gain_now[1], err_sum)
			+ scaled_product(gain_now[2], d);
		r.drive    = clamp32(-total);
		r.run_done = run_done;
		r.tuned    = tune_sel;
		return r;
	endfunction

	function automatic logic [31:0] pick_error(int unsigned mag_shift);
		logic [31:0] v;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 8) begin
			v = $urandom;
		end else if (sel < 12) begin
			case ($urandom_range(3))
				0:       v = Q16_MAX;
				1:       v = Q16_MIN;
				2:       v = '0;
				default: v = '1;
			endcase
		end else begin
			v = $urandom >> (mag_shift + $urandom_range(3));
			if ($urandom_range(1))
				v = -v;
		end
		return v;
	endfunction

	function automatic logic [31:0] pick_gain();
		logic [31:0] v;
		case ($urandom_range(5))
			0:       v = $urandom;
			1:       v = Q16_MAX;
			2:       v = Q16_MIN;
			default: begin
				v = $urandom_range(0, 32'h0010_0000);
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_checked, what, got, want);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		apply_write(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_error(logic signed [31:0] e);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= e;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		queued_outputs.push_back(controller_step(e));
		samples_sent++;
	endtask

	task automatic drain_outputs();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (queued_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// score saturates, so the first run can not count as better than the reset best
	task automatic test_saturated_score();
		write_reg(REG_TUNING_ENABLE, 32'd1);
		write_reg(REG_SETTLE_STEPS, 32'd0);
		write_reg(REG_LOOP_STEPS, 32'd6);
		repeat (6) send_error(Q16_MIN);
		drain_outputs();
	endtask

	task automatic test_field_extremes();
		write_reg(REG_TUNING_ENABLE, 32'd0);
		write_reg(REG_KP_INITIAL, Q16_MAX);
		write_reg(REG_KI_INITIAL, Q16_MIN);
		write_reg(REG_KD_INITIAL, Q16_MAX);
		send_error(32'sd0);
		send_error(32'sd1);
		send_error(-32'sd1);
		send_error(Q16_MAX);
		send_error(Q16_MAX);
		send_error(Q16_MIN);
		send_error(Q16_MIN);
		send_error(32'sh0001_0000);
		send_error(32'shFFFF_0000);
		drain_outputs();
	endtask

	// shrinking the run below the current count ends it on the next sample
	task automatic test_run_length_change();
		write_reg(REG_TUNING_ENABLE, 32'd1);
		write_reg(REG_SETTLE_STEPS, 32'd0);
		write_reg(REG_LOOP_STEPS, 32'd1150);
		repeat (5) send_error(Q16_MIN);
		drain_outputs();
		write_reg(REG_LOOP_STEPS, 32'd1);
		send_error(32'sh0000_8000);
		drain_outputs();
		write_reg(REG_TUNING_ENABLE, 32'd0);
		write_reg(REG_SETTLE_STEPS, 32'd100);
		write_reg(REG_LOOP_STEPS, 32'd1150);
		repeat (3) send_error(32'sh0002_0000);
		drain_outputs();
		write_reg(REG_LOOP_STEPS, 32'd2);
		write_reg(REG_SETTLE_STEPS, 32'd0);
		repeat (2) send_error(-32'sh0002_0000);
		drain_outputs();
		write_reg(REG_TUNING_ENABLE, 32'd1);
		write_reg(REG_SETTLE_STEPS, 32'd65535);
		write_reg(REG_LOOP_STEPS, 32'd65535);
		repeat (2) send_error(32'sh1234_5678);
		drain_outputs();
	endtask

	// short runs, error size shrinking phase by phase so better runs keep turning up
	task automatic test_twiddle_search();
		for (int phase = 0; phase < 14; phase++) begin
			write_reg(REG_TUNING_ENABLE, (phase % 5 == 3) ? 32'd0 : 32'd1);
			if (phase % 3 == 0) begin
				write_reg(REG_KP_INITIAL, pick_gain());
				write_reg(REG_KI_INITIAL, pick_gain());
				write_reg(REG_KD_INITIAL, pick_gain());
			end
			write_reg(REG_SETTLE_STEPS, $urandom_range(0, 4));
			write_reg(REG_LOOP_STEPS, $urandom_range(2, 9));
			repeat (60) send_error(pick_error(2 + 2 * phase));
			drain_outputs();
		end
	endtask

	task automatic test_output_stall();
		write_reg(REG_TUNING_ENABLE, 32'd1);
		write_reg(REG_SETTLE_STEPS, 32'd1);
		write_reg(REG_LOOP_STEPS, 32'd4);
		ready_hold = 150;
		repeat (60) send_error(pick_error(8));
		drain_outputs();
	endtask

	// full-scale errors and then random ones back to back with no idling on either side, short runs
	task automatic test_full_scale_burst();
		no_gaps = 1'b1;
		write_reg(REG_TUNING_ENABLE, 32'd1);
		write_reg(REG_KP_INITIAL, 32'sh0000_4000);
		write_reg(REG_KI_INITIAL, 32'sd1);
		write_reg(REG_KD_INITIAL, -32'sh0000_2000);
		write_reg(REG_SETTLE_STEPS, 32'd0);
		write_reg(REG_LOOP_STEPS, 32'd3);
		repeat (25) send_error(Q16_MAX);
		repeat (25) send_error(Q16_MIN);
		repeat (20) send_error(pick_error(4));
		drain_outputs();
		no_gaps = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				m_axis_tready <= 1'b0;
				ready_hold--;
			end else begin
				m_axis_tready <= no_gaps || ($urandom_range(99) >= 6);
			end
		end
	end

	always @(posedge clk) begin : check_results
		pid_output_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (queued_outputs.size() == 0) begin
				report_mismatch("unexpected transfer, drive", $signed(m_axis_tdata), 0);
			end else begin
				want = queued_outputs.pop_front();
				if (m_axis_tdata !== want.drive)
					report_mismatch("drive", $signed(m_axis_tdata), want.drive);
				if (m_axis_tuser[0] !== want.run_done)
					report_mismatch("run_finished", m_axis_tuser[0], want.run_done);
				if (m_axis_tuser[2:1] !== want.tuned)
					report_mismatch("tuned_gain_index", m_axis_tuser[2:1], want.tuned);
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("pid_controller_with_twiddle_tuning verification failed");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_TUNING_ENABLE;
		cfg_data      = '0;
		mismatches      = 0;
		samples_sent    = 0;
		results_checked = 0;
		runs_closed     = 0;
		runs_improved   = 0;
		idle_cycles     = 0;
		ready_hold      = 0;
		no_gaps         = 1'b0;
		reset_controller();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_saturated_score();
		test_field_extremes();
		test_run_length_change();
		test_twiddle_search();
		test_output_stall();
		test_full_scale_burst();
		drain_outputs();

		$display("%0d error samples sent, %0d results checked, %0d mismatches",
			samples_sent, results_checked, mismatches);
		$display("%0d tuning runs closed, %0d improved; full-scale bursts sent back to back",
			runs_closed, runs_improved);
		if (mismatches == 0 && queued_outputs.size() == 0) begin
			$display("pid_controller_with_twiddle_tuning verification clean");
		end else begin
			$display("pid_controller_with_twiddle_tuning verification failed");
		end
		$finish;
	end

endmodule
